/* src/bhr_pkg.sv */
package bhr_pkg;

  localparam int VALUE_W        = 16;
  localparam int S_TDATA_W      = 24;
  localparam int M_TDATA_W      = 24;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int TIME_BITS_DEF  = 16;
  localparam int VALUE_BITS_DEF = 16;
  localparam int DPW_RESET      = 400;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HOLD_DELAY          = 3'd0,
    REG_REPEAT_INTERVAL     = 3'd1,
    REG_DOUBLE_PRESS_WINDOW = 3'd2,
    REG_IS_DOUBLE_VARIANT   = 3'd3,
    REG_BUTTON_HAS_DOUBLE   = 3'd4,
    REG_BUTTON_HAS_HOLD     = 3'd5,
    REG_SKIP_RELEASE        = 3'd6
  } bhr_reg_t;

  typedef struct packed {
    logic               hold_fired_in;
    logic [VALUE_W-1:0] press_value;
    logic               mode;
  } bhr_item_t;

  typedef struct packed {
    logic               clear_hold_flag;
    logic               set_hold_flag;
    logic [VALUE_W-1:0] fire_value;
    logic               fire;
  } bhr_result_t;

  typedef struct packed {
    logic is_double_variant;
    logic button_has_double;
    logic button_has_hold;
    logic skip_release;
  } bhr_flags_t;

endpackage

/* src/bhr_stage.sv */
module bhr_stage import bhr_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             valid;
  logic [WIDTH-1:0] data;

  // takes a new transfer when empty or when the held one leaves in the same cycle
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

endmodule

/* src/bhr_core.sv */
module bhr_core import bhr_pkg::*; #(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 upd,
  input  bhr_item_t            item,
  input  logic [TIME_BITS-1:0] hold_delay,
  input  logic [TIME_BITS-1:0] repeat_interval,
  input  logic [TIME_BITS-1:0] double_press_window,
  input  bhr_flags_t           flags,
  output bhr_result_t          result
);

  localparam int CW = TIME_BITS + 1;
  localparam int VB = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

  logic          hold_pending, hold_pending_next;
  logic          repeat_running, repeat_running_next;
  logic          first_press_seen, first_press_seen_next;
  logic [CW-1:0] hold_elapsed, hold_elapsed_next;
  logic [CW-1:0] repeat_elapsed, repeat_elapsed_next;
  logic [CW-1:0] double_elapsed, double_elapsed_next;
  logic [VB-1:0] saved_value, saved_value_next;

  logic [CW-1:0] hold_inc, repeat_inc, double_inc;
  logic [CW-1:0] hd_ext, ri_ext, dpw_ext;
  logic [VB-1:0] v;
  logic          rel, hd_zero, ri_zero, partner, swallow;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    sat_inc = (&c) ? c : c + CW'(1);
  endfunction

  assign hold_inc   = sat_inc(hold_elapsed);
  assign repeat_inc = sat_inc(repeat_elapsed);
  assign double_inc = sat_inc(double_elapsed);
  assign hd_ext     = CW'(hold_delay);
  assign ri_ext     = CW'(repeat_interval);
  assign dpw_ext    = CW'(double_press_window);
  assign v          = item.press_value[VB-1:0];
  assign rel        = (v == '0);
  assign hd_zero    = (hold_delay == '0);
  assign ri_zero    = (repeat_interval == '0);
  // normal action that defers to a hold action on the same button
  assign partner    = !flags.is_double_variant && hd_zero && flags.button_has_hold;

  always_comb begin
    hold_pending_next     = hold_pending;
    repeat_running_next   = repeat_running;
    first_press_seen_next = first_press_seen;
    hold_elapsed_next     = hold_elapsed;
    repeat_elapsed_next   = repeat_elapsed;
    double_elapsed_next   = double_elapsed;
    saved_value_next      = saved_value;
    swallow               = 1'b0;
    result                = '0;

    if (item.mode) begin
      hold_elapsed_next   = hold_inc;
      repeat_elapsed_next = repeat_inc;
      double_elapsed_next = double_inc;
      if (!hd_zero && hold_pending && (hold_inc > hd_ext)) begin
        hold_pending_next = 1'b0;
        if (!ri_zero) begin
          repeat_running_next = 1'b1;
          repeat_elapsed_next = '0;
        end
        result.fire          = 1'b1;
        result.fire_value    = VALUE_W'(saved_value);
        result.set_hold_flag = 1'b1;
      end else if (!ri_zero && repeat_running && (repeat_inc > ri_ext)) begin
        repeat_elapsed_next = '0;
        result.fire         = 1'b1;
        result.fire_value   = VALUE_W'(saved_value);
      end
    end else begin
      if (rel) begin
        hold_pending_next   = 1'b0;
        repeat_running_next = 1'b0;
      end
      if (partner) begin
        if (!rel) begin
          saved_value_next       = v;
          result.clear_hold_flag = 1'b1;
        end else if (!item.hold_fired_in) begin
          result.fire       = 1'b1;
          result.fire_value = VALUE_W'(saved_value);
        end
      end else if (!(flags.skip_release && rel)) begin
        saved_value_next = v;
        if ((flags.is_double_variant || flags.button_has_double) && !rel) begin
          if (!first_press_seen || (double_elapsed > dpw_ext)) begin
            // first press opens the window
            first_press_seen_next = 1'b1;
            double_elapsed_next   = '0;
            swallow               = flags.is_double_variant;
          end else begin
            first_press_seen_next = 1'b0;
            swallow               = !flags.is_double_variant && hd_zero;
          end
        end
        if (!swallow) begin
          if (!ri_zero && !rel && hd_zero) begin
            repeat_running_next = 1'b1;
            repeat_elapsed_next = '0;
          end
          if (!hd_zero) begin
            if (!rel) begin
              hold_pending_next = 1'b1;
              hold_elapsed_next = '0;
            end
          end else begin
            result.fire       = 1'b1;
            result.fire_value = VALUE_W'(v);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_pending     <= 1'b0;
      repeat_running   <= 1'b0;
      first_press_seen <= 1'b0;
      hold_elapsed     <= '0;
      repeat_elapsed   <= '0;
      double_elapsed   <= '0;
      saved_value      <= '0;
    end else if (upd) begin
      hold_pending     <= hold_pending_next;
      repeat_running   <= repeat_running_next;
      first_press_seen <= first_press_seen_next;
      hold_elapsed     <= hold_elapsed_next;
      repeat_elapsed   <= repeat_elapsed_next;
      double_elapsed   <= double_elapsed_next;
      saved_value      <= saved_value_next;
    end
  end

  a_set_on_tick: assert property (@(posedge clk) disable iff (rst)
    (upd && result.set_hold_flag) |-> item.mode)
    else $error("hold flag set on a button event");

  a_clear_on_press: assert property (@(posedge clk) disable iff (rst)
    (upd && result.clear_hold_flag) |-> (!item.mode && !rel))
    else $error("hold flag cleared outside a press");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    (upd && result.set_hold_flag) |=> !hold_pending)
    else $error("hold still pending after hold fire");

  a_quiet_value: assert property (@(posedge clk) disable iff (rst)
    (upd && !result.fire) |-> (result.fire_value == '0))
    else $error("nonzero value without fire");

endmodule

/* src/button_hold_repeat_double_press_top.sv */
// each item passes through the input register and then the result register
// throughput: one item per cycle unless m_tready stalls; the state update sits between the
// input and result register; a stalled result freezes the state; the input register takes
// one more item and then holds s_tready low until the result register drains
// reset (rst, synchronous, active high) clears all timers and flags and loads the
// register defaults; double press window resets to 400 ticks, all else to zero
module button_hold_repeat_double_press_top import bhr_pkg::*; #(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_TDATA_W-1:0]   s_tdata,   // press_value[15:0], hold_fired_in, zero pad
  input  logic                   s_tuser,   // mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_TDATA_W-1:0]   m_tdata,   // fire, fire_value[15:0], set_hold_flag,
                                            // clear_hold_flag, zero pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ITEM_W = $bits(bhr_item_t);
  localparam int RES_W  = $bits(bhr_result_t);

  logic [TIME_BITS-1:0] hold_delay, repeat_interval, double_press_window;
  bhr_flags_t           flags;

  bhr_item_t   in_item, q_item;
  bhr_result_t core_res, q_res;
  logic        q_valid, q_ready;
  logic [ITEM_W-1:0] q_bits;
  logic [RES_W-1:0]  res_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_delay          <= '0;
      repeat_interval     <= '0;
      double_press_window <= TIME_BITS'(DPW_RESET);
      flags               <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bhr_reg_t'(cfg_index))
        REG_HOLD_DELAY:          hold_delay              <= TIME_BITS'(cfg_data);
        REG_REPEAT_INTERVAL:     repeat_interval         <= TIME_BITS'(cfg_data);
        REG_DOUBLE_PRESS_WINDOW: double_press_window     <= TIME_BITS'(cfg_data);
        REG_IS_DOUBLE_VARIANT:   flags.is_double_variant <= cfg_data[0];
        REG_BUTTON_HAS_DOUBLE:   flags.button_has_double <= cfg_data[0];
        REG_BUTTON_HAS_HOLD:     flags.button_has_hold   <= cfg_data[0];
        REG_SKIP_RELEASE:        flags.skip_release      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.mode          = s_tuser;
    in_item.press_value   = s_tdata[VALUE_W-1:0];
    in_item.hold_fired_in = s_tdata[VALUE_W];
  end

  bhr_stage #(.WIDTH(ITEM_W)) u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (in_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_bits)
  );

  assign q_item = bhr_item_t'(q_bits);

  // state advances on the transfer from the input register into the result register
  bhr_core #(.TIME_BITS(TIME_BITS), .VALUE_BITS(VALUE_BITS)) u_core (
    .clk                 (clk),
    .rst                 (rst),
    .upd                 (q_valid && q_ready),
    .item                (q_item),
    .hold_delay          (hold_delay),
    .repeat_interval     (repeat_interval),
    .double_press_window (double_press_window),
    .flags               (flags),
    .result              (core_res)
  );

  bhr_stage #(.WIDTH(RES_W)) u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_data   (core_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res_bits)
  );

  assign q_res   = bhr_result_t'(res_bits);
  assign m_tdata = M_TDATA_W'(q_res);

endmodule

/* tb/testbench.sv */
module testbench;
  import bhr_pkg::*;

  localparam int          RAND_ITEMS  = 1350;
  localparam int          RAND_PHASES = 8;
  localparam int          LONG_HOLD   = 600;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int          PAD_W       = M_TDATA_W - $bits(bhr_result_t);
  localparam logic [16:0] CNT_TOP     = '1;
  localparam bhr_result_t QUIET       = '0;

  typedef struct {
    logic        is_write;
    bhr_reg_t    reg_idx;
    logic [15:0] wdata;
    logic        tick;
    logic [15:0] value;
    logic        partner;
    int          count;
    logic        typed;
    bhr_result_t want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_HOLD_DELAY;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // copy of the block's registers and timers
  logic [15:0] hold_delay_r, repeat_ivl_r, dbl_window_r;
  logic        is_dbl_r, has_dbl_r, has_hold_r, skip_rel_r;
  logic        hold_pend, rep_run, first_seen;
  logic [16:0] hold_cnt, rep_cnt, dbl_cnt;
  logic [15:0] held_value;

  bhr_result_t pending_results[$];
  stim_row_t   dir_rows[$];
  int          mismatches = 0;
  int          sent_items = 0;
  int          burst_left = 0;
  int          long_holds_asked = 0;
  int unsigned cycle_count = 0;

  button_hold_repeat_double_press_top DUT (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [16:0] bump(logic [16:0] c);
    return (c == CNT_TOP) ? c : c + 17'd1;
  endfunction

  function automatic bhr_result_t qualify_item(logic tick, logic [15:0] v, logic partner);
    bhr_result_t r;
    logic        rel;
    r   = '0;
    rel = (v == 16'd0);
    if (tick) begin
      hold_cnt = bump(hold_cnt);
      rep_cnt  = bump(rep_cnt);
      dbl_cnt  = bump(dbl_cnt);
      if (hold_delay_r != 0 && hold_pend && hold_cnt > {1'b0, hold_delay_r}) begin
        hold_pend = 1'b0;
        // repeat timer restarts here, so it cannot also expire on this tick
        if (repeat_ivl_r != 0) begin
          rep_run = 1'b1;
          rep_cnt = '0;
        end
        r.fire          = 1'b1;
        r.fire_value    = held_value;
        r.set_hold_flag = 1'b1;
      end else if (repeat_ivl_r != 0 && rep_run && rep_cnt > {1'b0, repeat_ivl_r}) begin
        rep_cnt      = '0;
        r.fire       = 1'b1;
        r.fire_value = held_value;
      end
      return r;
    end
    if (rel) begin
      hold_pend = 1'b0;
      rep_run   = 1'b0;
    end
    // normal action deferring to a hold partner on the same button
    if (!is_dbl_r && hold_delay_r == 0 && has_hold_r) begin
      if (!rel) begin
        held_value        = v;
        r.clear_hold_flag = 1'b1;
      end else if (!partner) begin
        r.fire       = 1'b1;
        r.fire_value = held_value;
      end
      return r;
    end
    if (skip_rel_r && rel) return r;
    held_value = v;
    if ((is_dbl_r || has_dbl_r) && !rel) begin
      if (!first_seen || dbl_cnt > {1'b0, dbl_window_r}) begin
        first_seen = 1'b1;
        dbl_cnt    = '0;
        if (is_dbl_r) return r;
      end else begin
        first_seen = 1'b0;
        if (!is_dbl_r && hold_delay_r == 0) return r;
      end
    end
    if (repeat_ivl_r != 0 && !rel && hold_delay_r == 0) begin
      rep_run = 1'b1;
      rep_cnt = '0;
    end
    if (hold_delay_r != 0) begin
      if (!rel) begin
        hold_pend = 1'b1;
        hold_cnt  = '0;
      end
    end else begin
      r.fire       = 1'b1;
      r.fire_value = v;
    end
    return r;
  endfunction

  function automatic bhr_result_t outcome(logic f, logic [15:0] v, logic s, logic c);
    bhr_result_t r;
    r.fire            = f;
    r.fire_value      = v;
    r.set_hold_flag   = s;
    r.clear_hold_flag = c;
    return r;
  endfunction

  function automatic stim_row_t press_row(logic [15:0] v, logic partner, logic typed,
                                          bhr_result_t want);
    stim_row_t r;
    r          = '{reg_idx: REG_HOLD_DELAY, default: '0};
    r.value    = v;
    r.partner  = partner;
    r.count    = 1;
    r.typed    = typed;
    r.want     = want;
    return r;
  endfunction

  function automatic stim_row_t tick_row(int n, logic typed, bhr_result_t want);
    stim_row_t r;
    r       = '{reg_idx: REG_HOLD_DELAY, default: '0};
    r.tick  = 1'b1;
    r.count = n;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t write_row(bhr_reg_t idx, logic [15:0] d);
    stim_row_t r;
    r          = '{reg_idx: REG_HOLD_DELAY, default: '0};
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.wdata    = d;
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic logic [15:0] pick_delay();
    case ($urandom_range(0, 9))
      0, 1:    return 16'd0;
      8:       return 16'($urandom_range(7, 30));
      9:       return ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'd1;
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", field, want, got);
    end
  endtask

  // drop valid and wait until every expected result has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(bhr_reg_t idx, logic [15:0] d);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_HOLD_DELAY:          hold_delay_r = d;
      REG_REPEAT_INTERVAL:     repeat_ivl_r = d;
      REG_DOUBLE_PRESS_WINDOW: dbl_window_r = d;
      REG_IS_DOUBLE_VARIANT:   is_dbl_r     = d[0];
      REG_BUTTON_HAS_DOUBLE:   has_dbl_r    = d[0];
      REG_BUTTON_HAS_HOLD:     has_hold_r   = d[0];
      REG_SKIP_RELEASE:        skip_rel_r   = d[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(logic tick, logic [15:0] v, logic partner, logic typed,
                           bhr_result_t want);
    bhr_result_t predicted;
    int          gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= tick;
    s_tdata  <= {{(S_TDATA_W-VALUE_W-1){1'b0}}, partner, v};
    do @(posedge clk); while (s_tready !== 1'b1);
    predicted = qualify_item(tick, v, partner);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    sent_items++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic tick_run(int n);
    for (int i = 0; i < n; i++) send_item(1'b1, 16'($urandom), 1'($urandom), 1'b0, QUIET);
  endtask

  always @(posedge clk) begin : result_check
    bhr_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = bhr_result_t'(m_tdata[$bits(bhr_result_t)-1:0]);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %h with nothing expected", m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("fire", 32'(want.fire), 32'(got.fire));
        check_field("fire_value", 32'(want.fire_value), 32'(got.fire_value));
        check_field("set_hold_flag", 32'(want.set_hold_flag), 32'(got.set_hold_flag));
        check_field("clear_hold_flag", 32'(want.clear_hold_flag),
                    32'(got.clear_hold_flag));
        check_field("tdata pad", 32'd0, 32'(m_tdata[M_TDATA_W-1 -: PAD_W]));
      end
    end
  end

  // receiver: changing stall pattern, plus long hold-offs on request
  initial begin : receiver
    bit [31:0] rx_tick;
    int        hold_left;
    int        holds_taken;
    logic      ready;
    rx_tick     = 0;
    hold_left   = 0;
    holds_taken = 0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (holds_taken != long_holds_asked) begin
        holds_taken = long_holds_asked;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else begin
        case (rx_tick[9:8])
          2'd0:    ready = 1'b1;
          2'd1:    ready = (rx_tick[1:0] != 2'd0);
          2'd2:    ready = (rx_tick % 7) > 2;
          default: ready = rx_tick[2];
        endcase
      end
      m_tready <= ready;
    end
  end

  initial begin
    stim_row_t   r;
    logic [15:0] v;
    int          phase_start;

    hold_delay_r = '0;
    repeat_ivl_r = '0;
    dbl_window_r = 16'(DPW_RESET);
    is_dbl_r     = 1'b0;
    has_dbl_r    = 1'b0;
    has_hold_r   = 1'b0;
    skip_rel_r   = 1'b0;
    hold_pend    = 1'b0;
    rep_run      = 1'b0;
    first_seen   = 1'b0;
    hold_cnt     = '0;
    rep_cnt      = '0;
    dbl_cnt      = '0;
    held_value   = '0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // register defaults after reset: plain action fires on press and on release
    add_row(press_row(16'hFFFF, 1'b0, 1'b1, outcome(1'b1, 16'hFFFF, 1'b0, 1'b0)));
    add_row(press_row(16'h0000, 1'b0, 1'b1, outcome(1'b1, 16'h0000, 1'b0, 1'b0)));
    add_row(tick_row(1, 1'b1, QUIET));
    add_row(press_row(16'h0001, 1'b1, 1'b1, outcome(1'b1, 16'h0001, 1'b0, 1'b0)));
    // ignored release
    add_row(write_row(REG_SKIP_RELEASE, 16'hFFFF));
    add_row(press_row(16'h0000, 1'b1, 1'b1, QUIET));
    add_row(write_row(REG_SKIP_RELEASE, 16'hFFFE));
    // hold partner: press clears the flag, release fires unless the hold fired
    add_row(write_row(REG_BUTTON_HAS_HOLD, 16'h0001));
    add_row(press_row(16'h8000, 1'b1, 1'b1, outcome(1'b0, 16'h0000, 1'b0, 1'b1)));
    add_row(press_row(16'h0000, 1'b1, 1'b1, QUIET));
    add_row(press_row(16'h1234, 1'b0, 1'b1, outcome(1'b0, 16'h0000, 1'b0, 1'b1)));
    add_row(press_row(16'h0000, 1'b0, 1'b1, outcome(1'b1, 16'h1234, 1'b0, 1'b0)));
    // hold delay then auto-repeat
    add_row(write_row(REG_BUTTON_HAS_HOLD, 16'h0000));
    add_row(write_row(REG_HOLD_DELAY, 16'd2));
    add_row(write_row(REG_REPEAT_INTERVAL, 16'd3));
    add_row(press_row(16'hABCD, 1'b0, 1'b1, QUIET));
    add_row(tick_row(2, 1'b1, QUIET));
    add_row(tick_row(1, 1'b1, outcome(1'b1, 16'hABCD, 1'b1, 1'b0)));
    add_row(tick_row(4, 1'b0, QUIET));
    add_row(press_row(16'h0000, 1'b1, 1'b0, QUIET));
    add_row(tick_row(1, 1'b0, QUIET));
    // double press, normal action then double variant
    add_row(write_row(REG_HOLD_DELAY, 16'd0));
    add_row(write_row(REG_REPEAT_INTERVAL, 16'd1));
    add_row(write_row(REG_BUTTON_HAS_DOUBLE, 16'h0001));
    add_row(write_row(REG_DOUBLE_PRESS_WINDOW, 16'd3));
    add_row(press_row(16'h5555, 1'b0, 1'b0, QUIET));
    add_row(tick_row(2, 1'b0, QUIET));
    add_row(press_row(16'h6666, 1'b1, 1'b1, QUIET));
    add_row(write_row(REG_IS_DOUBLE_VARIANT, 16'h0001));
    add_row(press_row(16'h7777, 1'b0, 1'b1, QUIET));
    add_row(press_row(16'h7778, 1'b0, 1'b0, QUIET));
    add_row(press_row(16'h0000, 1'b1, 1'b0, QUIET));
    add_row(tick_row(4, 1'b0, QUIET));
    add_row(press_row(16'h9999, 1'b0, 1'b0, QUIET));
    add_row(write_row(REG_DOUBLE_PRESS_WINDOW, 16'd0));
    add_row(press_row(16'h4321, 1'b0, 1'b0, QUIET));
    add_row(press_row(16'h4322, 1'b0, 1'b0, QUIET));

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.is_write) begin
        write_reg(r.reg_idx, r.wdata);
      end else begin
        for (int k = 0; k < r.count; k++) begin
          if (r.tick) send_item(1'b1, 16'($urandom), 1'($urandom), r.typed, r.want);
          else send_item(1'b0, r.value, r.partner, r.typed, r.want);
        end
      end
    end

    // longest hold delay and repeat interval: nothing fires within a short run
    write_reg(REG_HOLD_DELAY, 16'hFFFF);
    write_reg(REG_REPEAT_INTERVAL, 16'hFFFF);
    write_reg(REG_IS_DOUBLE_VARIANT, 16'h0000);
    write_reg(REG_BUTTON_HAS_DOUBLE, 16'h0000);
    send_item(1'b0, 16'h2468, 1'b0, 1'b0, QUIET);
    tick_run(40);
    send_item(1'b0, 16'h0000, 1'b0, 1'b0, QUIET);

    // widest window: a press some ticks later still lands inside it
    write_reg(REG_HOLD_DELAY, 16'd0);
    write_reg(REG_REPEAT_INTERVAL, 16'd0);
    write_reg(REG_DOUBLE_PRESS_WINDOW, 16'hFFFF);
    write_reg(REG_IS_DOUBLE_VARIANT, 16'h0001);
    send_item(1'b0, 16'h1357, 1'b0, 1'b0, QUIET);
    tick_run(40);
    send_item(1'b0, 16'h1358, 1'b0, 1'b0, QUIET);
    send_item(1'b0, 16'h1359, 1'b0, 1'b0, QUIET);
    send_item(1'b0, 16'h0000, 1'b0, 1'b0, QUIET);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_reg(REG_HOLD_DELAY, pick_delay());
      write_reg(REG_REPEAT_INTERVAL, pick_delay());
      write_reg(REG_DOUBLE_PRESS_WINDOW, pick_delay());
      write_reg(REG_IS_DOUBLE_VARIANT, 16'($urandom));
      write_reg(REG_BUTTON_HAS_DOUBLE, 16'($urandom));
      write_reg(REG_BUTTON_HAS_HOLD, 16'($urandom));
      write_reg(REG_SKIP_RELEASE, 16'($urandom));
      // receiver holds off while items keep coming, so the input side backs up
      if (ph == 2 || ph == 5) long_holds_asked++;
      phase_start = sent_items;
      while (sent_items - phase_start < RAND_ITEMS / RAND_PHASES) begin
        if ($urandom_range(0, 6) != 0) begin
          v = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
          send_item(1'b0, v, 1'($urandom), 1'b0, QUIET);
          tick_run($urandom_range(0, 8));
          if ($urandom_range(0, 2) == 0) begin
            send_item(1'b0, 16'($urandom_range(1, 65535)), 1'($urandom), 1'b0, QUIET);
            tick_run($urandom_range(0, 5));
          end
          send_item(1'b0, 16'h0000, 1'($urandom), 1'b0, QUIET);
          tick_run($urandom_range(0, 10));
        end else begin
          v = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom);
          send_item(1'($urandom), v, 1'($urandom), 1'b0, QUIET);
        end
      end
    end

    settle();
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
